@@ hdl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition on every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Check a consequent in the same cycle as its antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/eip_hdr_pkg.sv @@
package eip_hdr_pkg;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_NOT_IPV4 = 2'd1,
      STATUS_ERROR    = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      KIND_NONE = 2'd0,
      KIND_TCP  = 2'd1,
      KIND_UDP  = 2'd2
   } kind_type;

   parameter logic [15:0] ETH_TYPE_VLAN = 16'h8100;
   parameter logic [15:0] ETH_TYPE_QINQ = 16'h88A8;
   parameter logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
   parameter logic [7:0]  IHL_MASK      = 8'h0F;
   parameter logic [7:0]  PROTO_TCP     = 8'd6;
   parameter logic [7:0]  PROTO_UDP     = 8'd17;

   parameter int unsigned DST_MAC_END     = 6;
   parameter int unsigned SRC_MAC_END     = 12;
   parameter int unsigned ETH_PLAIN_LEN   = 14;
   parameter int unsigned ETH_TAGGED_LEN  = 18;
   parameter int unsigned TYPE_LAST_POS   = 13;
   parameter int unsigned TAG_TYPE_HI_POS = 16;
   parameter int unsigned TAG_TYPE_LO_POS = 17;
   parameter int unsigned IP_MIN_LEN      = 20;
   parameter int unsigned IP_FRONT_LEN    = 8;
   parameter int unsigned IP_MIDDLE_END   = 16;
   parameter int unsigned L4_CAPTURE_LEN  = 16;
   parameter int unsigned TCP_HDR_LEN     = 20;
   parameter int unsigned UDP_HDR_LEN     = 8;

   typedef struct packed {
      logic valid;
      logic last;
   } step_type;

   typedef struct packed {
      logic [7:0]  total;
      logic        tag_seen;
      logic [15:0] inner_type;
      logic [5:0]  ip_len;
      logic [47:0] dst_mac;
      logic [47:0] src_mac;
      logic [15:0] outer_type;
      logic [63:0] ip_front;
      logic [63:0] ip_middle;
      logic [31:0] ip_dst;
      logic [63:0] l4_first;
      logic [63:0] l4_second;
   } hdr_view_type;

endpackage

@@ hdl/eip_hdr_capture.sv @@
module eip_hdr_capture (
   input  logic                       clock,
   input  logic                       reset,
   input  eip_hdr_pkg::step_type      step,
   input  logic [7:0]                 data_byte,
   output eip_hdr_pkg::hdr_view_type  view
);
   import eip_hdr_pkg::*;

   logic [6:0]  pos_ff, pos_in;
   logic        tag_ff, tag_in;
   logic [15:0] inner_ff, inner_in;
   logic [5:0]  ip_len_ff, ip_len_in;
   logic [47:0] dst_ff, dst_in;
   logic [47:0] src_ff, src_in;
   logic [15:0] outer_ff, outer_in;
   logic [63:0] ip_front_ff, ip_front_in;
   logic [63:0] ip_middle_ff, ip_middle_in;
   logic [31:0] ip_dst_ff, ip_dst_in;
   logic [63:0] l4_first_ff, l4_first_in;
   logic [63:0] l4_second_ff, l4_second_in;

   logic [6:0] ip_start, ip_off, l4_start, l4_off;
   logic       in_ip, in_l4;
   logic [7:0] ihl;

   always_comb begin
      ip_start = tag_ff ? 7'(ETH_TAGGED_LEN) : 7'(ETH_PLAIN_LEN);
      ip_off   = pos_ff - ip_start;
      in_ip    = (pos_ff >= ip_start) && (ip_off < 7'(IP_MIN_LEN));
      l4_start = ip_start + {1'b0, ip_len_ff};
      l4_off   = pos_ff - l4_start;
      in_l4    = (ip_len_ff >= 6'(IP_MIN_LEN)) && (pos_ff >= l4_start)
                 && (l4_off < 7'(L4_CAPTURE_LEN));
      ihl      = data_byte & IHL_MASK;
   end

   always_comb begin
      pos_in       = (pos_ff == 7'h7F) ? pos_ff : pos_ff + 7'd1;
      tag_in       = tag_ff;
      inner_in     = inner_ff;
      ip_len_in    = ip_len_ff;
      dst_in       = dst_ff;
      src_in       = src_ff;
      outer_in     = outer_ff;
      ip_front_in  = ip_front_ff;
      ip_middle_in = ip_middle_ff;
      ip_dst_in    = ip_dst_ff;
      l4_first_in  = l4_first_ff;
      l4_second_in = l4_second_ff;
      if (pos_ff < 7'(DST_MAC_END)) begin
         dst_in = {dst_ff[39:0], data_byte};
      end else if (pos_ff < 7'(SRC_MAC_END)) begin
         src_in = {src_ff[39:0], data_byte};
      end else if (pos_ff < 7'(ETH_PLAIN_LEN)) begin
         outer_in = {outer_ff[7:0], data_byte};
         inner_in = outer_in;
         if (pos_ff == 7'(TYPE_LAST_POS)) begin
            tag_in = (outer_in == ETH_TYPE_VLAN) || (outer_in == ETH_TYPE_QINQ);
         end
      end else begin
         if (tag_ff && ((pos_ff == 7'(TAG_TYPE_HI_POS)) || (pos_ff == 7'(TAG_TYPE_LO_POS))))
         begin
            inner_in = {inner_ff[7:0], data_byte};
         end
         if (in_ip) begin
            if (ip_off == 7'd0) begin
               ip_len_in = {ihl[3:0], 2'b00};
            end
            if (ip_off < 7'(IP_FRONT_LEN)) begin
               ip_front_in = {ip_front_ff[55:0], data_byte};
            end else if (ip_off < 7'(IP_MIDDLE_END)) begin
               ip_middle_in = {ip_middle_ff[55:0], data_byte};
            end else begin
               ip_dst_in = {ip_dst_ff[23:0], data_byte};
            end
         end
         if (in_l4) begin
            if (!l4_off[3]) begin
               l4_first_in = {l4_first_ff[55:0], data_byte};
            end else begin
               l4_second_in = {l4_second_ff[55:0], data_byte};
            end
         end
      end
   end

   always_comb begin
      view.total      = {1'b0, pos_ff} + 8'd1;
      view.tag_seen   = tag_in;
      view.inner_type = inner_in;
      view.ip_len     = ip_len_in;
      view.dst_mac    = dst_in;
      view.src_mac    = src_in;
      view.outer_type = outer_in;
      view.ip_front   = ip_front_in;
      view.ip_middle  = ip_middle_in;
      view.ip_dst     = ip_dst_in;
      view.l4_first   = l4_first_in;
      view.l4_second  = l4_second_in;
   end

   always_ff @(posedge clock) begin
      if (reset || (step.valid && step.last)) begin
         pos_ff       <= '0;
         tag_ff       <= 1'b0;
         inner_ff     <= '0;
         ip_len_ff    <= '0;
         dst_ff       <= '0;
         src_ff       <= '0;
         outer_ff     <= '0;
         ip_front_ff  <= '0;
         ip_middle_ff <= '0;
         ip_dst_ff    <= '0;
         l4_first_ff  <= '0;
         l4_second_ff <= '0;
      end else if (step.valid) begin
         pos_ff       <= pos_in;
         tag_ff       <= tag_in;
         inner_ff     <= inner_in;
         ip_len_ff    <= ip_len_in;
         dst_ff       <= dst_in;
         src_ff       <= src_in;
         outer_ff     <= outer_in;
         ip_front_ff  <= ip_front_in;
         ip_middle_ff <= ip_middle_in;
         ip_dst_ff    <= ip_dst_in;
         l4_first_ff  <= l4_first_in;
         l4_second_ff <= l4_second_in;
      end
   end

endmodule

@@ hdl/ethernet_ipv4_header_parser_top.sv @@
// A result is loaded into the result register as the final byte of a frame leaves the input register.
// Throughput: one byte per cycle; the final byte waits only while a result is stalled.
// The per-frame capture state sits behind one input register and feeds the result register.
// Reset (synchronous, active high) empties both registers and clears the capture state;
// the state also clears after every final byte.
module ethernet_ipv4_header_parser_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_frame_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [1:0]  rsp_l4_kind,
   output logic [47:0] rsp_dst_mac,
   output logic [47:0] rsp_src_mac,
   output logic [15:0] rsp_outer_type,
   output logic [63:0] rsp_ip_front,
   output logic [63:0] rsp_ip_middle,
   output logic [31:0] rsp_ip_dst,
   output logic [31:0] rsp_l4_ports,
   output logic [63:0] rsp_tcp_seq_ack,
   output logic [31:0] rsp_l4_tail
);
   import eip_hdr_pkg::*;

   `include "assert_macros.svh"

   logic         in_valid_ff;
   logic [7:0]   in_byte_ff;
   logic         in_end_ff;
   logic         out_free, consume, load;
   step_type     step;
   hdr_view_type view;

   logic         rsp_valid_ff;
   status_type   status_ff, status_in;
   kind_type     kind_ff, kind_in;
   logic [47:0]  dst_ff, dst_in, src_ff, src_in;
   logic [15:0]  outer_ff, outer_in;
   logic [63:0]  front_ff, front_in, middle_ff, middle_in;
   logic [31:0]  ip_dst_ff, ip_dst_in;
   logic [31:0]  ports_ff, ports_in;
   logic [63:0]  seq_ack_ff, seq_ack_in;
   logic [31:0]  tail_ff, tail_in;

   logic [7:0]   ip_start, l4_start;
   logic [7:0]   proto;
   logic         have_eth, have_ip;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign consume    = in_valid_ff && (!in_end_ff || out_free);
   assign load       = consume && in_end_ff;
   assign req_stall  = in_valid_ff && !consume;
   assign step.valid = consume;
   assign step.last  = in_end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         in_valid_ff <= 1'b1;
      end else if (consume) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_data_byte;
         in_end_ff  <= req_frame_end;
      end
   end

   eip_hdr_capture u_capture (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .data_byte (in_byte_ff),
      .view      (view)
   );

   always_comb begin
      ip_start  = view.tag_seen ? 8'(ETH_TAGGED_LEN) : 8'(ETH_PLAIN_LEN);
      l4_start  = ip_start + {2'b00, view.ip_len};
      proto     = view.ip_middle[55:48];
      have_eth  = (view.total >= 8'(ETH_PLAIN_LEN))
                  && (!view.tag_seen || (view.total >= 8'(ETH_TAGGED_LEN)));
      have_ip   = 1'b0;
      status_in = STATUS_ERROR;
      kind_in   = KIND_NONE;
      if (have_eth) begin
         if (view.inner_type != ETH_TYPE_IPV4) begin
            status_in = STATUS_NOT_IPV4;
         end else if (view.total >= ip_start + 8'(IP_MIN_LEN)) begin
            have_ip = 1'b1;
            if ((view.ip_len >= 6'(IP_MIN_LEN)) && (view.total >= l4_start)) begin
               case (proto)
                  PROTO_TCP: begin
                     if (view.total >= l4_start + 8'(TCP_HDR_LEN)) begin
                        status_in = STATUS_OK;
                        kind_in   = KIND_TCP;
                     end
                  end
                  PROTO_UDP: begin
                     if (view.total >= l4_start + 8'(UDP_HDR_LEN)) begin
                        status_in = STATUS_OK;
                        kind_in   = KIND_UDP;
                     end
                  end
                  default: begin
                     status_in = STATUS_OK;
                  end
               endcase
            end
         end
      end
   end

   always_comb begin
      dst_in     = have_eth ? view.dst_mac : '0;
      src_in     = have_eth ? view.src_mac : '0;
      outer_in   = have_eth ? view.outer_type : '0;
      front_in   = have_ip ? view.ip_front : '0;
      middle_in  = have_ip ? view.ip_middle : '0;
      ip_dst_in  = have_ip ? view.ip_dst : '0;
      ports_in   = '0;
      seq_ack_in = '0;
      tail_in    = '0;
      case (kind_in)
         KIND_TCP: begin
            ports_in   = view.l4_first[63:32];
            seq_ack_in = {view.l4_first[31:0], view.l4_second[63:32]};
            tail_in    = view.l4_second[31:0];
         end
         KIND_UDP: begin
            ports_in = view.l4_first[63:32];
            tail_in  = view.l4_first[31:0];
         end
         default: begin
            ports_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         status_ff  <= status_in;
         kind_ff    <= kind_in;
         dst_ff     <= dst_in;
         src_ff     <= src_in;
         outer_ff   <= outer_in;
         front_ff   <= front_in;
         middle_ff  <= middle_in;
         ip_dst_ff  <= ip_dst_in;
         ports_ff   <= ports_in;
         seq_ack_ff <= seq_ack_in;
         tail_ff    <= tail_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_l4_kind     = kind_ff;
   assign rsp_dst_mac     = dst_ff;
   assign rsp_src_mac     = src_ff;
   assign rsp_outer_type  = outer_ff;
   assign rsp_ip_front    = front_ff;
   assign rsp_ip_middle   = middle_ff;
   assign rsp_ip_dst      = ip_dst_ff;
   assign rsp_l4_ports    = ports_ff;
   assign rsp_tcp_seq_ack = seq_ack_ff;
   assign rsp_l4_tail     = tail_ff;

   `ASSERT_IMPLIES(a_stall_only_on_end, req_stall, in_valid_ff && in_end_ff && rsp_valid_ff, "input stalled without a blocked final byte")
   `ASSERT_NEXT(a_end_gives_item, load, rsp_valid_ff, "final byte consumed without a result")
   `ASSERT_IMPLIES(a_kind_needs_ok, rsp_valid_ff && (status_ff != STATUS_OK), kind_ff == KIND_NONE, "transport kind set on a failed frame")
   `ASSERT_IMPLIES(a_non_ip_clean, rsp_valid_ff && (status_ff == STATUS_NOT_IPV4), (front_ff == '0) && (ip_dst_ff == '0) && (ports_ff == '0), "IP fields set on a non-IPv4 frame")

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps

module tb;
   import eip_hdr_pkg::*;

   localparam int TAG_NONE = 0;
   localparam int TAG_VLAN = 1;
   localparam int TAG_QINQ = 2;
   localparam int POS_MAX = 127;
   localparam int HOLD_CYCLES = 300;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES = 10;

   typedef struct packed {
      status_type  status;
      kind_type    l4_kind;
      logic [47:0] dst_mac;
      logic [47:0] src_mac;
      logic [15:0] outer_type;
      logic [63:0] ip_front;
      logic [63:0] ip_middle;
      logic [31:0] ip_dst;
      logic [31:0] l4_ports;
      logic [63:0] tcp_seq_ack;
      logic [31:0] l4_tail;
   } parsed_frame_t;

   class header_tracker;
      int pos;
      bit tag_on;
      bit [15:0] inner;
      bit [5:0] ip_len;
      bit [47:0] dmac;
      bit [47:0] smac;
      bit [15:0] otype;
      bit [63:0] ipw0;
      bit [63:0] ipw1;
      bit [31:0] ipdst;
      bit [63:0] l4w0;
      bit [63:0] l4w1;
      parsed_frame_t expected_frames[$];
      int mismatches;

      function new();
         mismatches = 0;
         clear_state();
      endfunction

      function void clear_state();
         pos = 0;
         tag_on = 0;
         inner = '0;
         ip_len = '0;
         dmac = '0;
         smac = '0;
         otype = '0;
         ipw0 = '0;
         ipw1 = '0;
         ipdst = '0;
         l4w0 = '0;
         l4w1 = '0;
      endfunction

      function void take_byte(bit [7:0] b, bit last);
         int p;
         int ipstart;
         int l4start;
         int total;
         bit [7:0] proto;
         bit have_eth;
         bit have_ip;
         parsed_frame_t r;
         p = pos;
         if (p < DST_MAC_END) begin
            dmac = {dmac[39:0], b};
         end else if (p < SRC_MAC_END) begin
            smac = {smac[39:0], b};
         end else if (p < ETH_PLAIN_LEN) begin
            otype = {otype[7:0], b};
            inner = otype;
            if (p == TYPE_LAST_POS)
               tag_on = (otype == ETH_TYPE_VLAN || otype == ETH_TYPE_QINQ);
         end else begin
            ipstart = tag_on ? ETH_TAGGED_LEN : ETH_PLAIN_LEN;
            if (tag_on && (p == TAG_TYPE_HI_POS || p == TAG_TYPE_LO_POS))
               inner = {inner[7:0], b};
            if (p >= ipstart && p < ipstart + IP_MIN_LEN) begin
               if (p == ipstart)
                  ip_len = 6'((b & IHL_MASK) * 4);
               if (p - ipstart < IP_FRONT_LEN)
                  ipw0 = {ipw0[55:0], b};
               else if (p - ipstart < IP_MIDDLE_END)
                  ipw1 = {ipw1[55:0], b};
               else
                  ipdst = {ipdst[23:0], b};
            end
            if (ip_len >= IP_MIN_LEN) begin
               l4start = ipstart + ip_len;
               if (p >= l4start && p < l4start + L4_CAPTURE_LEN) begin
                  if (p - l4start < 8)
                     l4w0 = {l4w0[55:0], b};
                  else
                     l4w1 = {l4w1[55:0], b};
               end
            end
         end
         if (pos < POS_MAX)
            pos++;
         if (!last)
            return;

         total = p + 1;
         ipstart = tag_on ? ETH_TAGGED_LEN : ETH_PLAIN_LEN;
         l4start = ipstart + ip_len;
         proto = ipw1[55:48];
         r = '0;
         r.status = STATUS_ERROR;
         r.l4_kind = KIND_NONE;
         have_eth = 0;
         have_ip = 0;
         if (total >= ETH_PLAIN_LEN && (!tag_on || total >= ETH_TAGGED_LEN)) begin
            have_eth = 1;
            if (inner != ETH_TYPE_IPV4) begin
               r.status = STATUS_NOT_IPV4;
            end else if (total >= ipstart + IP_MIN_LEN) begin
               have_ip = 1;
               if (ip_len >= IP_MIN_LEN && total >= l4start) begin
                  if (proto == PROTO_TCP) begin
                     if (total >= l4start + TCP_HDR_LEN) begin
                        r.status = STATUS_OK;
                        r.l4_kind = KIND_TCP;
                     end
                  end else if (proto == PROTO_UDP) begin
                     if (total >= l4start + UDP_HDR_LEN) begin
                        r.status = STATUS_OK;
                        r.l4_kind = KIND_UDP;
                     end
                  end else begin
                     r.status = STATUS_OK;
                  end
               end
            end
         end
         if (have_eth) begin
            r.dst_mac = dmac;
            r.src_mac = smac;
            r.outer_type = otype;
         end
         if (have_ip) begin
            r.ip_front = ipw0;
            r.ip_middle = ipw1;
            r.ip_dst = ipdst;
         end
         if (r.l4_kind == KIND_TCP) begin
            r.l4_ports = l4w0[63:32];
            r.tcp_seq_ack = {l4w0[31:0], l4w1[63:32]};
            r.l4_tail = l4w1[31:0];
         end else if (r.l4_kind == KIND_UDP) begin
            r.l4_ports = l4w0[63:32];
            r.l4_tail = l4w0[31:0];
         end
         expected_frames.push_back(r);
         clear_state();
      endfunction

      function void compare(string what, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch in %s: expected %h, got %h", what, want, got);
         end
      endfunction

      function void check_frame(parsed_frame_t got);
         parsed_frame_t want;
         if (expected_frames.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result with none expected: status %0d", got.status);
            return;
         end
         want = expected_frames.pop_front();
         compare("status", want.status, got.status);
         compare("l4_kind", want.l4_kind, got.l4_kind);
         compare("dst_mac", want.dst_mac, got.dst_mac);
         compare("src_mac", want.src_mac, got.src_mac);
         compare("outer_type", want.outer_type, got.outer_type);
         compare("ip_front", want.ip_front, got.ip_front);
         compare("ip_middle", want.ip_middle, got.ip_middle);
         compare("ip_dst", want.ip_dst, got.ip_dst);
         compare("l4_ports", want.l4_ports, got.l4_ports);
         compare("tcp_seq_ack", want.tcp_seq_ack, got.tcp_seq_ack);
         compare("l4_tail", want.l4_tail, got.l4_tail);
      endfunction

      function int pending();
         return expected_frames.size();
      endfunction

      function bit failed();
         return mismatches != 0 || expected_frames.size() != 0;
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_data_byte;
   logic        req_frame_end;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_status;
   logic [1:0]  rsp_l4_kind;
   logic [47:0] rsp_dst_mac;
   logic [47:0] rsp_src_mac;
   logic [15:0] rsp_outer_type;
   logic [63:0] rsp_ip_front;
   logic [63:0] rsp_ip_middle;
   logic [31:0] rsp_ip_dst;
   logic [31:0] rsp_l4_ports;
   logic [63:0] rsp_tcp_seq_ack;
   logic [31:0] rsp_l4_tail;

   header_tracker sb = new();
   bit [7:0] frame_q[$];
   bit steady = 0;
   bit hold_req = 0;
   int bytes_sent = 0;
   int idle_cycles = 0;
   parsed_frame_t got_frame;

   ethernet_ipv4_header_parser_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_frame_end   (req_frame_end),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_l4_kind     (rsp_l4_kind),
      .rsp_dst_mac     (rsp_dst_mac),
      .rsp_src_mac     (rsp_src_mac),
      .rsp_outer_type  (rsp_outer_type),
      .rsp_ip_front    (rsp_ip_front),
      .rsp_ip_middle   (rsp_ip_middle),
      .rsp_ip_dst      (rsp_ip_dst),
      .rsp_l4_ports    (rsp_l4_ports),
      .rsp_tcp_seq_ack (rsp_tcp_seq_ack),
      .rsp_l4_tail     (rsp_l4_tail)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void build_frame(int tag, bit [15:0] etype, bit [3:0] ihl,
                                       bit [7:0] proto, int l4_len);
      bit [15:0] outer;
      frame_q = {};
      repeat (12) frame_q.push_back(8'($urandom));
      if (tag != TAG_NONE) begin
         outer = (tag == TAG_VLAN) ? ETH_TYPE_VLAN : ETH_TYPE_QINQ;
         frame_q.push_back(outer[15:8]);
         frame_q.push_back(outer[7:0]);
         repeat (2) frame_q.push_back(8'($urandom));
      end
      frame_q.push_back(etype[15:8]);
      frame_q.push_back(etype[7:0]);
      frame_q.push_back({$urandom_range(1) ? 4'h4 : 4'($urandom), ihl});
      repeat (8) frame_q.push_back(8'($urandom));
      frame_q.push_back(proto);
      repeat (10) frame_q.push_back(8'($urandom));
      if (ihl > 5)
         repeat (ihl * 4 - IP_MIN_LEN) frame_q.push_back(8'($urandom));
      repeat (l4_len) frame_q.push_back(8'($urandom));
   endfunction

   function automatic void fill_frame(int len, bit scramble, bit [7:0] value);
      frame_q = {};
      repeat (len) frame_q.push_back(scramble ? 8'($urandom) : value);
   endfunction

   task automatic send_byte(bit [7:0] b, bit last);
      @(negedge clock);
      if (!steady)
         while ($urandom_range(99) < 27) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_frame_end <= last;
      @(posedge clock);
      while (req_stall !== 1'b0)
         @(posedge clock);
      sb.take_byte(b, last);
      bytes_sent++;
   endtask

   task automatic send_frame(int len);
      for (int i = 0; i < len; i++)
         send_byte(i < frame_q.size() ? frame_q[i] : 8'($urandom), i == len - 1);
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
   endtask

   task automatic random_frame();
      int r;
      int sel;
      int tag;
      int nat;
      int len;
      int l4_len;
      bit [3:0] ihl;
      bit [7:0] proto;
      bit [15:0] etype;
      r = $urandom_range(99);
      tag = $urandom_range(3);
      if (tag > TAG_QINQ)
         tag = TAG_NONE;
      if (r < 70) begin
         if ($urandom_range(9) == 0)
            ihl = 4'($urandom_range(4));
         else
            ihl = $urandom_range(1) ? 4'd5 : 4'($urandom_range(15, 5));
         sel = $urandom_range(19);
         proto = sel < 9 ? PROTO_TCP : sel < 17 ? PROTO_UDP : 8'($urandom);
         l4_len = proto == PROTO_TCP ? TCP_HDR_LEN :
                  proto == PROTO_UDP ? UDP_HDR_LEN : $urandom_range(8);
         build_frame(tag, ETH_TYPE_IPV4, ihl, proto, l4_len);
         nat = frame_q.size();
         sel = $urandom_range(19);
         if (sel < 15)
            len = nat + $urandom_range(12);
         else if (sel < 18)
            len = $urandom_range(nat, 1);
         else
            len = $urandom_range(180, nat);
      end else if (r < 85) begin
         do
            etype = 16'($urandom);
         while (etype == ETH_TYPE_IPV4);
         build_frame(tag, etype, 4'($urandom), 8'($urandom), 0);
         len = $urandom_range(60, 1);
      end else begin
         len = $urandom_range(40, 1);
         fill_frame(len, 1, 8'h00);
      end
      send_frame(len);
   endtask

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !steady && ($urandom_range(99) < 27);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         got_frame = {rsp_status, rsp_l4_kind, rsp_dst_mac, rsp_src_mac, rsp_outer_type,
                      rsp_ip_front, rsp_ip_middle, rsp_ip_dst, rsp_l4_ports,
                      rsp_tcp_seq_ack, rsp_l4_tail};
         sb.check_frame(got_frame);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data_byte = 8'h00;
      req_frame_end = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      build_frame(TAG_NONE, ETH_TYPE_IPV4, 5, PROTO_TCP, TCP_HDR_LEN);
      send_frame(1);
      send_frame(13);
      build_frame(TAG_VLAN, ETH_TYPE_IPV4, 5, PROTO_UDP, UDP_HDR_LEN);
      send_frame(16);
      build_frame(TAG_QINQ, ETH_TYPE_IPV4, 5, PROTO_UDP, UDP_HDR_LEN);
      send_frame(17);
      build_frame(TAG_NONE, 16'h86DD, 5, PROTO_TCP, 0);
      send_frame(60);
      build_frame(TAG_VLAN, 16'h0806, 5, PROTO_TCP, 0);
      send_frame(18);
      build_frame(TAG_NONE, ETH_TYPE_IPV4, 5, PROTO_TCP, TCP_HDR_LEN);
      send_frame(33);
      build_frame(TAG_NONE, ETH_TYPE_IPV4, 4, PROTO_TCP, TCP_HDR_LEN);
      send_frame(54);
      build_frame(TAG_NONE, ETH_TYPE_IPV4, 0, PROTO_UDP, UDP_HDR_LEN);
      send_frame(40);
      build_frame(TAG_NONE, ETH_TYPE_IPV4, 15, PROTO_TCP, TCP_HDR_LEN);
      send_frame(64);
      build_frame(TAG_NONE, ETH_TYPE_IPV4, 5, PROTO_TCP, TCP_HDR_LEN);
      send_frame(frame_q.size() - 1);
      build_frame(TAG_VLAN, ETH_TYPE_IPV4, 5, PROTO_UDP, UDP_HDR_LEN);
      send_frame(frame_q.size() - 1);
      build_frame(TAG_NONE, ETH_TYPE_IPV4, 5, PROTO_TCP, TCP_HDR_LEN);
      send_frame(frame_q.size());
      build_frame(TAG_QINQ, ETH_TYPE_IPV4, 7, PROTO_UDP, UDP_HDR_LEN);
      send_frame(frame_q.size());
      build_frame(TAG_QINQ, ETH_TYPE_IPV4, 15, PROTO_TCP, TCP_HDR_LEN);
      send_frame(frame_q.size() + 10);
      build_frame(TAG_NONE, ETH_TYPE_IPV4, 5, 8'd1, 0);
      send_frame(34);
      build_frame(TAG_VLAN, ETH_TYPE_IPV4, 6, 8'd47, 0);
      send_frame(120);
      build_frame(TAG_NONE, ETH_TYPE_IPV4, 5, PROTO_TCP, TCP_HDR_LEN);
      send_frame(130);
      fill_frame(24, 0, 8'hFF);
      send_frame(24);
      fill_frame(24, 0, 8'h00);
      send_frame(24);

      for (int n = 0; bytes_sent < 1250 || n < 6; n++) begin
         steady = (n >= 2 && n < 6);
         if (n == 0) begin
            // hold results back and keep offering short frames
            hold_req = 1;
            repeat (5) begin
               fill_frame(12, 1, 8'h00);
               send_frame(12);
            end
         end
         if (n == 1)
            wait_for_results();
         random_frame();
      end

      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (!sb.failed())
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end
endmodule
